>>> design/dsrsc_pkg.sv
package dsrsc_pkg;

  localparam int unsigned SPEED_W = 8;
  localparam int unsigned SERVO_W = 12;
  localparam int unsigned PULSE_W = 16;
  localparam int unsigned TIME_W  = 16;
  localparam int unsigned LEVEL_W = 8;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 12;

  localparam logic signed [SPEED_W-1:0] SPEED_MAX = 8'sd100;
  localparam logic signed [SPEED_W-1:0] SPEED_MIN = -8'sd100;
  localparam logic [6:0] LEVEL_MAX = 7'd100;

  // Division of the turn product by 100 through a scaled reciprocal.
  localparam int unsigned PROD_W   = 19;
  localparam int unsigned RECIP_W  = 20;
  localparam int unsigned RECIP_SH = 26;
  localparam logic [RECIP_W-1:0] RECIP_K = 20'd671089;

  localparam logic [7:0]         ACCEL_RST     = 8'd5;
  localparam logic [7:0]         DECEL_RST     = 8'd10;
  localparam logic [7:0]         MIN_CHG_RST   = 8'd1;
  localparam logic [SERVO_W-1:0] LEFT_RST      = 12'd1000;
  localparam logic [SERVO_W-1:0] CENTER_RST    = 12'd1500;
  localparam logic [SERVO_W-1:0] RIGHT_RST     = 12'd2000;
  localparam logic [SERVO_W-1:0] DEADBAND_RST  = 12'd5;

  typedef enum logic [2:0] {
    CMD_TICK     = 3'd0,
    CMD_STRAIGHT = 3'd1,
    CMD_PULSE    = 3'd2,
    CMD_LEFT     = 3'd3,
    CMD_RIGHT    = 3'd4,
    CMD_STOP     = 3'd5,
    CMD_STEER    = 3'd6
  } cmd_t;

  typedef enum logic [1:0] {
    MA_NONE = 2'd0,
    MA_SET  = 2'd1,
    MA_STOP = 2'd2
  } mact_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ACCEL    = 3'd0,
    CFG_DECEL    = 3'd1,
    CFG_MIN_CHG  = 3'd2,
    CFG_LEFT     = 3'd3,
    CFG_CENTER   = 3'd4,
    CFG_RIGHT    = 3'd5,
    CFG_DEADBAND = 3'd6,
    CFG_DIRECT   = 3'd7
  } cfg_idx_t;

  typedef struct packed {
    logic [2:0]                command;
    logic signed [SPEED_W-1:0] speed;
    logic [LEVEL_W-1:0]        turn_level;
    logic [PULSE_W-1:0]        pulse;
    logic                      link_fault;
  } in_item_t;

  typedef struct packed {
    logic [1:0]                motor_action;
    logic signed [SPEED_W-1:0] motor_speed;
    logic                      servo_write;
    logic [SERVO_W-1:0]        servo_pulse;
    logic [TIME_W-1:0]         servo_time_ms;
    logic signed [SPEED_W-1:0] ramp_speed;
  } out_item_t;

endpackage

>>> design/drive_speed_ramp_steering_cmd.sv
// Channel  Direction  Handshake             Payload
// in_      input      in_valid / in_stall   dsrsc_pkg::in_item_t
// out_     output     out_valid / out_stall dsrsc_pkg::out_item_t
// cfg_     input      cfg_we                cfg_index, cfg_wdata
//
// One command per cycle is taken while in_stall is low, first into the input register.
// The turn product is formed ahead of the input register, and the divide by 100, clamps,
// ramp and write decisions sit between the input register and the result register.
// Reset is synchronous and active low; it restores the register defaults and the state.
// A stalled result holds the result register; the input register still fills behind it.
module drive_speed_ramp_steering_cmd #(
  parameter logic [15:0] CENTER_MOVE_MS = 16'd200,
  parameter logic [15:0] TURN_MOVE_MS   = 16'd200,
  parameter logic [15:0] STEER_MOVE_MS  = 16'd500
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  dsrsc_pkg::in_item_t                   in_data,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output dsrsc_pkg::out_item_t                  out_data,
  input  logic                                  cfg_we,
  input  logic [dsrsc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [dsrsc_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

  localparam int unsigned SW = dsrsc_pkg::SERVO_W;
  localparam int unsigned PW = dsrsc_pkg::PROD_W;

  logic [7:0]    accel_r, decel_r, min_chg_r;
  logic [SW-1:0] left_r, center_r, right_r, deadband_r;
  logic          direct_r;

  logic signed [7:0] target_r, ramp_r, last_motor_r;
  logic              motor_valid_r;
  logic [SW-1:0]     last_servo_r;
  logic              servo_valid_r;

  logic                 a_valid_r;
  dsrsc_pkg::in_item_t  a_data_r;
  logic [PW-1:0]        a_mag_r;
  logic                 a_neg_r;

  logic                 out_valid_r;
  dsrsc_pkg::out_item_t out_data_r;

  logic in_acc, out_load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      accel_r    <= dsrsc_pkg::ACCEL_RST;
      decel_r    <= dsrsc_pkg::DECEL_RST;
      min_chg_r  <= dsrsc_pkg::MIN_CHG_RST;
      left_r     <= dsrsc_pkg::LEFT_RST;
      center_r   <= dsrsc_pkg::CENTER_RST;
      right_r    <= dsrsc_pkg::RIGHT_RST;
      deadband_r <= dsrsc_pkg::DEADBAND_RST;
      direct_r   <= 1'b1;
    end else if (cfg_we) begin
      unique case (dsrsc_pkg::cfg_idx_t'(cfg_index))
        dsrsc_pkg::CFG_ACCEL:    accel_r    <= cfg_wdata[7:0];
        dsrsc_pkg::CFG_DECEL:    decel_r    <= cfg_wdata[7:0];
        dsrsc_pkg::CFG_MIN_CHG:  min_chg_r  <= cfg_wdata[7:0];
        dsrsc_pkg::CFG_LEFT:     left_r     <= cfg_wdata[SW-1:0];
        dsrsc_pkg::CFG_CENTER:   center_r   <= cfg_wdata[SW-1:0];
        dsrsc_pkg::CFG_RIGHT:    right_r    <= cfg_wdata[SW-1:0];
        dsrsc_pkg::CFG_DEADBAND: deadband_r <= cfg_wdata[SW-1:0];
        dsrsc_pkg::CFG_DIRECT:   direct_r   <= cfg_wdata[0];
      endcase
    end
  end

  // Handshake between the two register stages.
  assign out_load  = a_valid_r && (!out_valid_r || !out_stall);
  assign in_stall  = a_valid_r && !out_load;
  assign in_acc    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Turn span times saturated level, taken ahead of the input register.
  logic [6:0]          lvl_sat;
  logic signed [13:0]  span;
  logic [SW-1:0]       span_mag;
  logic [PW-1:0]       mag_nxt;

  always_comb begin
    lvl_sat = (in_data.turn_level > 8'(dsrsc_pkg::LEVEL_MAX)) ? dsrsc_pkg::LEVEL_MAX
                                                              : in_data.turn_level[6:0];
    if (in_data.command == dsrsc_pkg::CMD_RIGHT) begin
      span = signed'({2'b00, right_r}) - signed'({2'b00, center_r});
    end else begin
      span = signed'({2'b00, center_r}) - signed'({2'b00, left_r});
    end
    span_mag = span[13] ? SW'(-span) : span[SW-1:0];
    mag_nxt  = PW'(span_mag * lvl_sat);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (in_acc) begin
      a_valid_r <= 1'b1;
    end else if (out_load) begin
      a_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      a_data_r <= in_data;
      a_mag_r  <= mag_nxt;
      a_neg_r  <= span[13];
    end
  end

  // Servo path.
  logic [PW+dsrsc_pkg::RECIP_W-1:0] q_prod;
  logic [SW-1:0]        q_mag;
  logic signed [14:0]   q_s, turn_r15;
  logic [15:0]          turn_p, req_p, clamp1;
  logic [SW-1:0]        servo_p, servo_diff;
  logic                 servo_req, servo_do;
  logic [15:0]          servo_time;
  logic                 is_left;

  always_comb begin
    q_prod   = a_mag_r * dsrsc_pkg::RECIP_K;
    q_mag    = q_prod[dsrsc_pkg::RECIP_SH +: SW];
    q_s      = a_neg_r ? -signed'({3'b000, q_mag}) : signed'({3'b000, q_mag});
    is_left  = (a_data_r.command == dsrsc_pkg::CMD_LEFT);
    turn_r15 = is_left ? (signed'({3'b000, center_r}) - q_s)
                       : (signed'({3'b000, center_r}) + q_s);
    turn_p   = 16'(turn_r15);

    servo_req  = 1'b1;
    req_p      = {4'b0000, center_r};
    servo_time = CENTER_MOVE_MS;
    unique case (a_data_r.command)
      dsrsc_pkg::CMD_STRAIGHT, dsrsc_pkg::CMD_STOP: begin
        req_p      = {4'b0000, center_r};
        servo_time = CENTER_MOVE_MS;
      end
      dsrsc_pkg::CMD_PULSE: begin
        req_p      = a_data_r.pulse;
        servo_time = TURN_MOVE_MS;
      end
      dsrsc_pkg::CMD_LEFT, dsrsc_pkg::CMD_RIGHT: begin
        req_p      = turn_p;
        servo_time = TURN_MOVE_MS;
      end
      dsrsc_pkg::CMD_STEER: begin
        req_p      = a_data_r.pulse;
        servo_time = STEER_MOVE_MS;
      end
      default: begin
        servo_req = 1'b0;
      end
    endcase

    // The left bound is applied first, so the result never exceeds the right bound.
    clamp1     = (req_p < {4'b0000, left_r}) ? {4'b0000, left_r} : req_p;
    servo_p    = (clamp1 > {4'b0000, right_r}) ? right_r : clamp1[SW-1:0];
    servo_diff = (servo_p > last_servo_r) ? (servo_p - last_servo_r)
                                          : (last_servo_r - servo_p);
    servo_do   = servo_req && (!servo_valid_r || servo_diff >= deadband_r);
  end

  // Motor path.
  logic signed [7:0] spd_sat, ramp_nxt, motor_s;
  logic signed [9:0] cur10, tgt10, step10, up10, dn10;
  logic              decel_sel, motor_req, mvalid_eff, motor_do;
  logic signed [8:0] mdiff_s;
  logic [8:0]        mdiff;
  logic              is_go;

  always_comb begin
    if (a_data_r.speed > dsrsc_pkg::SPEED_MAX) begin
      spd_sat = dsrsc_pkg::SPEED_MAX;
    end else if (a_data_r.speed < dsrsc_pkg::SPEED_MIN) begin
      spd_sat = dsrsc_pkg::SPEED_MIN;
    end else begin
      spd_sat = a_data_r.speed;
    end

    cur10     = 10'(ramp_r);
    tgt10     = 10'(target_r);
    decel_sel = (target_r == 8'sd0) || ((ramp_r > 8'sd0) != (target_r > 8'sd0));
    step10    = signed'({2'b00, (decel_sel ? decel_r : accel_r)});
    up10      = cur10 + step10;
    dn10      = cur10 - step10;
    if (ramp_r == target_r) begin
      ramp_nxt = ramp_r;
    end else if (target_r > ramp_r) begin
      ramp_nxt = (up10 > tgt10) ? target_r : up10[7:0];
    end else begin
      ramp_nxt = (dn10 < tgt10) ? target_r : dn10[7:0];
    end

    is_go = (a_data_r.command == dsrsc_pkg::CMD_STRAIGHT) ||
            (a_data_r.command == dsrsc_pkg::CMD_PULSE) ||
            (a_data_r.command == dsrsc_pkg::CMD_LEFT) ||
            (a_data_r.command == dsrsc_pkg::CMD_RIGHT);

    motor_req  = 1'b0;
    motor_s    = 8'sd0;
    mvalid_eff = motor_valid_r;
    if (a_data_r.command == dsrsc_pkg::CMD_TICK) begin
      motor_req = 1'b1;
      motor_s   = ramp_nxt;
    end else if (is_go) begin
      motor_req = direct_r;
      motor_s   = spd_sat;
    end else if (a_data_r.command == dsrsc_pkg::CMD_STOP) begin
      motor_req  = 1'b1;
      mvalid_eff = 1'b0;
    end

    mdiff_s  = 9'(motor_s) - 9'(last_motor_r);
    mdiff    = mdiff_s[8] ? 9'(-mdiff_s) : mdiff_s;
    motor_do = motor_req && (!mvalid_eff || mdiff >= {1'b0, min_chg_r});
  end

  // State update and result, both on the move into the result register.
  logic signed [7:0] target_nxt, ramp_sp_nxt, last_motor_nxt;
  logic              motor_valid_nxt;
  logic [SW-1:0]     last_servo_nxt;
  logic              servo_valid_nxt;
  dsrsc_pkg::out_item_t res_nxt;

  always_comb begin
    target_nxt      = target_r;
    ramp_sp_nxt     = ramp_r;
    last_motor_nxt  = last_motor_r;
    motor_valid_nxt = mvalid_eff;
    last_servo_nxt  = last_servo_r;
    servo_valid_nxt = servo_valid_r;

    if (a_data_r.command == dsrsc_pkg::CMD_TICK) begin
      ramp_sp_nxt = ramp_nxt;
    end else if (is_go) begin
      target_nxt = spd_sat;
      if (direct_r) begin
        ramp_sp_nxt = spd_sat;
      end
    end else if (a_data_r.command == dsrsc_pkg::CMD_STOP) begin
      target_nxt  = 8'sd0;
      ramp_sp_nxt = 8'sd0;
    end

    if (motor_do) begin
      if (a_data_r.link_fault) begin
        motor_valid_nxt = 1'b0;
      end else begin
        last_motor_nxt  = motor_s;
        motor_valid_nxt = 1'b1;
      end
    end
    if (a_data_r.command == dsrsc_pkg::CMD_STOP) begin
      last_motor_nxt = 8'sd0;
    end

    if (servo_do) begin
      last_servo_nxt  = servo_p;
      servo_valid_nxt = 1'b1;
    end

    res_nxt.motor_action  = motor_do ? ((motor_s == 8'sd0) ? dsrsc_pkg::MA_STOP
                                                           : dsrsc_pkg::MA_SET)
                                     : dsrsc_pkg::MA_NONE;
    res_nxt.motor_speed   = motor_do ? motor_s : 8'sd0;
    res_nxt.servo_write   = servo_do;
    res_nxt.servo_pulse   = servo_do ? servo_p : '0;
    res_nxt.servo_time_ms = servo_do ? servo_time : '0;
    res_nxt.ramp_speed    = ramp_sp_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r      <= 8'sd0;
      ramp_r        <= 8'sd0;
      last_motor_r  <= 8'sd0;
      motor_valid_r <= 1'b0;
      last_servo_r  <= dsrsc_pkg::CENTER_RST;
      servo_valid_r <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      if (out_load) begin
        target_r      <= target_nxt;
        ramp_r        <= ramp_sp_nxt;
        last_motor_r  <= last_motor_nxt;
        motor_valid_r <= motor_valid_nxt;
        last_servo_r  <= last_servo_nxt;
        servo_valid_r <= servo_valid_nxt;
        out_valid_r   <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r   <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= res_nxt;
    end
  end

`ifndef SYNTHESIS
  a_ramp_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_data_r.ramp_speed <= dsrsc_pkg::SPEED_MAX &&
                     out_data_r.ramp_speed >= dsrsc_pkg::SPEED_MIN))
    else $error("ramp speed outside its range");

  a_set_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.motor_action == dsrsc_pkg::MA_SET) |->
      (out_data_r.motor_speed != 8'sd0))
    else $error("set speed write carries a zero speed");

  a_stop_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && a_data_r.command == dsrsc_pkg::CMD_STOP) |=>
      (last_motor_r == 8'sd0 && ramp_r == 8'sd0 && target_r == 8'sd0 &&
       out_data_r.motor_action == dsrsc_pkg::MA_STOP))
    else $error("stop transfer did not clear the motor state");

  a_no_servo_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_data_r.servo_write) |->
      (out_data_r.servo_pulse == '0 && out_data_r.servo_time_ms == '0))
    else $error("servo fields set without a servo write");
`endif

endmodule

>>> test/drive_speed_ramp_steering_cmd_checker.sv
`timescale 1ns / 100ps
module drive_speed_ramp_steering_cmd_checker #(
  parameter logic [15:0] CENTER_MOVE_MS = 16'd200,
  parameter logic [15:0] TURN_MOVE_MS   = 16'd200,
  parameter logic [15:0] STEER_MOVE_MS  = 16'd500
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  input  logic                             in_stall,
  input  dsrsc_pkg::in_item_t              in_data,
  input  logic                             out_valid,
  input  logic                             out_stall,
  input  dsrsc_pkg::out_item_t             out_data,
  input  logic                             cfg_we,
  input  logic [dsrsc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dsrsc_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output int                               errors,
  output int                               pending
);

  localparam int unsigned SW = dsrsc_pkg::SERVO_W;

  logic [7:0]    accel_step;
  logic [7:0]    decel_step;
  logic [7:0]    min_change;
  logic [SW-1:0] left_lim;
  logic [SW-1:0] center_pos;
  logic [SW-1:0] right_lim;
  logic [SW-1:0] dead_band;
  logic          direct_set;

  logic signed [dsrsc_pkg::SPEED_W-1:0] goal_speed;
  logic signed [dsrsc_pkg::SPEED_W-1:0] ramp_now;
  logic signed [dsrsc_pkg::SPEED_W-1:0] sent_speed;
  logic                                 sent_ok;
  logic [SW-1:0]                        sent_pulse;
  logic                                 pulse_ok;

  dsrsc_pkg::out_item_t drive_results_q[$];

  function automatic int clamp_speed(input int spd);
    if (spd > 100) return 100;
    if (spd < -100) return -100;
    return spd;
  endfunction

  function automatic int next_ramp(input int cur, input int tgt);
    int step;
    int nxt;
    if (cur == tgt) return cur;
    step = (tgt == 0 || ((cur > 0) != (tgt > 0))) ? int'(decel_step) : int'(accel_step);
    if (tgt > cur) begin
      nxt = cur + step;
      if (nxt > tgt) nxt = tgt;
    end else begin
      nxt = cur - step;
      if (nxt < tgt) nxt = tgt;
    end
    return nxt;
  endfunction

  function automatic int turn_target(input logic [SW-1:0] lim,
                                     input logic [dsrsc_pkg::LEVEL_W-1:0] level,
                                     input logic left);
    int lvl;
    int span;
    int q;
    int r;
    lvl = (level > 8'd100) ? 100 : int'(level);
    span = left ? int'(center_pos) - int'(lim) : int'(lim) - int'(center_pos);
    q = span * lvl / 100;
    r = left ? int'(center_pos) - q : int'(center_pos) + q;
    return r & 32'hFFFF;
  endfunction

  task automatic motor_send(input int spd, input logic fault,
                            inout dsrsc_pkg::out_item_t res);
    int diff;
    spd = clamp_speed(spd);
    diff = spd - int'(sent_speed);
    if (diff < 0) diff = -diff;
    if (!sent_ok || diff >= int'(min_change)) begin
      res.motor_action = (spd == 0) ? dsrsc_pkg::MA_STOP : dsrsc_pkg::MA_SET;
      res.motor_speed  = 8'(spd);
      if (!fault) begin
        sent_speed = 8'(spd);
        sent_ok    = 1'b1;
      end else begin
        sent_ok = 1'b0;
      end
    end
  endtask

  task automatic servo_send(input int p, input logic [15:0] ms,
                            inout dsrsc_pkg::out_item_t res);
    int diff;
    if (p < int'(left_lim)) p = int'(left_lim);
    if (p > int'(right_lim)) p = int'(right_lim);
    diff = p - int'(sent_pulse);
    if (diff < 0) diff = -diff;
    if (!pulse_ok || diff >= int'(dead_band)) begin
      res.servo_write   = 1'b1;
      res.servo_pulse   = 12'(p);
      res.servo_time_ms = ms;
      sent_pulse        = 12'(p);
      pulse_ok          = 1'b1;
    end
  endtask

  task automatic set_goal(input logic signed [dsrsc_pkg::SPEED_W-1:0] spd,
                          input logic fault, inout dsrsc_pkg::out_item_t res);
    goal_speed = 8'(clamp_speed(int'(spd)));
    if (direct_set) begin
      ramp_now = goal_speed;
      motor_send(int'(ramp_now), fault, res);
    end
  endtask

  task automatic advance_drive(input dsrsc_pkg::in_item_t item,
                               output dsrsc_pkg::out_item_t res);
    res = '0;
    unique case (item.command)
      dsrsc_pkg::CMD_TICK: begin
        ramp_now = 8'(next_ramp(int'(ramp_now), int'(goal_speed)));
        motor_send(int'(ramp_now), item.link_fault, res);
      end
      dsrsc_pkg::CMD_STRAIGHT: begin
        set_goal($signed(item.speed), item.link_fault, res);
        servo_send(int'(center_pos), CENTER_MOVE_MS, res);
      end
      dsrsc_pkg::CMD_PULSE: begin
        set_goal($signed(item.speed), item.link_fault, res);
        servo_send(int'(item.pulse), TURN_MOVE_MS, res);
      end
      dsrsc_pkg::CMD_LEFT: begin
        set_goal($signed(item.speed), item.link_fault, res);
        servo_send(turn_target(left_lim, item.turn_level, 1'b1), TURN_MOVE_MS, res);
      end
      dsrsc_pkg::CMD_RIGHT: begin
        set_goal($signed(item.speed), item.link_fault, res);
        servo_send(turn_target(right_lim, item.turn_level, 1'b0), TURN_MOVE_MS, res);
      end
      dsrsc_pkg::CMD_STOP: begin
        goal_speed = '0;
        ramp_now   = '0;
        sent_ok    = 1'b0;
        motor_send(0, item.link_fault, res);
        sent_speed = '0;
        servo_send(int'(center_pos), CENTER_MOVE_MS, res);
      end
      dsrsc_pkg::CMD_STEER: begin
        servo_send(int'(item.pulse), STEER_MOVE_MS, res);
      end
      default: begin
      end
    endcase
    res.ramp_speed = ramp_now;
  endtask

  task automatic apply_cfg();
    unique case (dsrsc_pkg::cfg_idx_t'(cfg_index))
      dsrsc_pkg::CFG_ACCEL:    accel_step = cfg_wdata[7:0];
      dsrsc_pkg::CFG_DECEL:    decel_step = cfg_wdata[7:0];
      dsrsc_pkg::CFG_MIN_CHG:  min_change = cfg_wdata[7:0];
      dsrsc_pkg::CFG_LEFT:     left_lim   = cfg_wdata[SW-1:0];
      dsrsc_pkg::CFG_CENTER:   center_pos = cfg_wdata[SW-1:0];
      dsrsc_pkg::CFG_RIGHT:    right_lim  = cfg_wdata[SW-1:0];
      dsrsc_pkg::CFG_DEADBAND: dead_band  = cfg_wdata[SW-1:0];
      dsrsc_pkg::CFG_DIRECT:   direct_set = cfg_wdata[0];
      default: begin
      end
    endcase
  endtask

  task automatic check_field(input string what, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t %s mismatch: expected %h, actual %h", $time, what, want, got);
    end
  endtask

  always @(posedge clk) begin
    dsrsc_pkg::out_item_t want;
    if (!rst_n) begin
      accel_step  = dsrsc_pkg::ACCEL_RST;
      decel_step  = dsrsc_pkg::DECEL_RST;
      min_change  = dsrsc_pkg::MIN_CHG_RST;
      left_lim    = dsrsc_pkg::LEFT_RST;
      center_pos  = dsrsc_pkg::CENTER_RST;
      right_lim   = dsrsc_pkg::RIGHT_RST;
      dead_band   = dsrsc_pkg::DEADBAND_RST;
      direct_set  = 1'b1;
      goal_speed  = '0;
      ramp_now    = '0;
      sent_speed  = '0;
      sent_ok     = 1'b0;
      sent_pulse  = dsrsc_pkg::CENTER_RST;
      pulse_ok    = 1'b0;
      drive_results_q.delete();
      errors      = 0;
    end else begin
      if (cfg_we) apply_cfg();
      if (in_valid && !in_stall) begin
        advance_drive(in_data, want);
        drive_results_q.push_back(want);
      end
      if (out_valid && !out_stall) begin
        if (drive_results_q.size() == 0) begin
          errors++;
          $display("%0t unexpected transfer: expected none, actual %h", $time, out_data);
        end else begin
          want = drive_results_q.pop_front();
          check_field("motor_action", 16'(want.motor_action), 16'(out_data.motor_action));
          check_field("motor_speed", 16'(want.motor_speed), 16'(out_data.motor_speed));
          check_field("servo_write", 16'(want.servo_write), 16'(out_data.servo_write));
          check_field("servo_pulse", 16'(want.servo_pulse), 16'(out_data.servo_pulse));
          check_field("servo_time_ms", want.servo_time_ms, out_data.servo_time_ms);
          check_field("ramp_speed", 16'(want.ramp_speed), 16'(out_data.ramp_speed));
        end
      end
    end
    pending = drive_results_q.size();
  end

endmodule

>>> test/tb_drive_speed_ramp_steering_cmd.sv
`timescale 1ns / 100ps
module tb_drive_speed_ramp_steering_cmd;

  localparam logic [15:0] CENTER_MS     = 16'd200;
  localparam logic [15:0] TURN_MS       = 16'd200;
  localparam logic [15:0] STEER_MS      = 16'd500;
  localparam logic [2:0]  CMD_UNUSED    = 3'd7;
  localparam int          RANDOM_PHASES = 10;
  localparam int          PHASE_ITEMS   = 175;

  logic                             clk       = 1'b0;
  logic                             rst_n     = 1'b0;
  logic                             in_valid  = 1'b0;
  logic                             in_stall;
  dsrsc_pkg::in_item_t              in_data   = '0;
  logic                             out_valid;
  logic                             out_stall = 1'b0;
  dsrsc_pkg::out_item_t             out_data;
  logic                             cfg_we    = 1'b0;
  logic [dsrsc_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [dsrsc_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;
  int                               errors;
  int                               pending;
  int                               calm_left = 0;
  logic [15:0]                      pulse_anchor = 16'd1500;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  drive_speed_ramp_steering_cmd #(
    .CENTER_MOVE_MS(CENTER_MS),
    .TURN_MOVE_MS  (TURN_MS),
    .STEER_MOVE_MS (STEER_MS)
  ) u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  drive_speed_ramp_steering_cmd_checker #(
    .CENTER_MOVE_MS(CENTER_MS),
    .TURN_MOVE_MS  (TURN_MS),
    .STEER_MOVE_MS (STEER_MS)
  ) u_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .errors   (errors),
    .pending  (pending)
  );

  function automatic int pick_pause();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 88) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic dsrsc_pkg::in_item_t mk_cmd(input logic [2:0] cmd, input int spd,
                                                 input int lvl, input int pls,
                                                 input logic fault);
    dsrsc_pkg::in_item_t it;
    it.command    = cmd;
    it.speed      = 8'(spd);
    it.turn_level = 8'(lvl);
    it.pulse      = 16'(pls);
    it.link_fault = fault;
    return it;
  endfunction

  function automatic int rand_speed();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 25) return int'($urandom_range(0, 255));
    if (roll < 45) return $urandom_range(0, 1) ? int'($urandom_range(90, 127))
                                               : -int'($urandom_range(90, 128));
    if (roll < 65) return int'($urandom_range(0, 20)) - 10;
    if (roll < 75) return 0;
    return int'($urandom_range(0, 200)) - 100;
  endfunction

  function automatic int rand_level();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 50) return $urandom_range(0, 100);
    if (roll < 70) return $urandom_range(100, 255);
    if (roll < 80) return 0;
    return $urandom_range(0, 255);
  endfunction

  function automatic int rand_pulse();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 35) begin
      pulse_anchor = 16'($urandom_range(0, 4095));
    end else if (roll < 60) begin
      pulse_anchor = 16'($urandom_range(0, 65535));
    end else begin
      pulse_anchor = pulse_anchor + 16'($urandom_range(0, 24)) - 16'd12;
    end
    return int'(pulse_anchor);
  endfunction

  function automatic dsrsc_pkg::in_item_t rand_item(input logic [2:0] cmd);
    return mk_cmd(cmd, rand_speed(), rand_level(), rand_pulse(), $urandom_range(0, 7) == 0);
  endfunction

  task automatic send_cmd(input dsrsc_pkg::in_item_t item);
    int gap;
    gap = (calm_left > 0) ? 0 : pick_pause();
    if (calm_left > 0) begin
      calm_left--;
    end else if ($urandom_range(0, 79) == 0) begin
      calm_left = 40;
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic write_reg(input dsrsc_pkg::cfg_idx_t idx, input int val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val[dsrsc_pkg::CFG_DATA_W-1:0];
    @(negedge clk);
  endtask

  task automatic program_regs(input int acc, input int dec, input int minc, input int lft,
                              input int ctr, input int rgt, input int dbd, input int dir);
    write_reg(dsrsc_pkg::CFG_ACCEL, acc);
    write_reg(dsrsc_pkg::CFG_DECEL, dec);
    write_reg(dsrsc_pkg::CFG_MIN_CHG, minc);
    write_reg(dsrsc_pkg::CFG_LEFT, lft);
    write_reg(dsrsc_pkg::CFG_CENTER, ctr);
    write_reg(dsrsc_pkg::CFG_RIGHT, rgt);
    write_reg(dsrsc_pkg::CFG_DEADBAND, dbd);
    write_reg(dsrsc_pkg::CFG_DIRECT, dir);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic random_setting();
    int lft;
    int ctr;
    int rgt;
    if ($urandom_range(0, 4) == 0) begin
      lft = $urandom_range(0, 4095);
      ctr = $urandom_range(0, 4095);
      rgt = $urandom_range(0, 4095);
    end else begin
      lft = $urandom_range(0, 2000);
      rgt = $urandom_range(lft, 4095);
      ctr = $urandom_range(lft, rgt);
    end
    program_regs($urandom_range(1, 200), $urandom_range(1, 200),
                 $urandom_range(0, 1) ? $urandom_range(0, 10) : $urandom_range(0, 200),
                 lft, ctr, rgt,
                 ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4095) : $urandom_range(0, 40),
                 $urandom_range(0, 1));
  endtask

  // Most traffic is a heading command followed by a run of ticks so the ramp gets
  // somewhere; the rest is single commands of any code, stops and occasional drains.
  task automatic run_random(input int count);
    int done;
    int ticks;
    logic [2:0] cmd;
    done = 0;
    while (done < count) begin
      if ($urandom_range(0, 9) < 6) begin
        cmd = 3'($urandom_range(dsrsc_pkg::CMD_STRAIGHT, dsrsc_pkg::CMD_RIGHT));
        send_cmd(rand_item(cmd));
        ticks = $urandom_range(0, 12);
        repeat (ticks) send_cmd(rand_item(dsrsc_pkg::CMD_TICK));
        done += 1 + ticks;
        if ($urandom_range(0, 9) == 0) begin
          send_cmd(rand_item(dsrsc_pkg::CMD_STOP));
          done++;
        end
      end else begin
        cmd = 3'($urandom_range(dsrsc_pkg::CMD_TICK, CMD_UNUSED));
        send_cmd(rand_item(cmd));
        done++;
      end
      if ($urandom_range(0, 149) == 0) drain();
    end
    drain();
  endtask

  initial begin
    int run;
    int hold;
    @(negedge clk);
    forever begin
      run = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 150) : $urandom_range(1, 8);
      out_stall <= 1'b0;
      repeat (run) @(negedge clk);
      hold = 1 + pick_pause();
      out_stall <= 1'b1;
      repeat (hold) @(negedge clk);
    end
  end

  initial begin
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_cmd(mk_cmd(dsrsc_pkg::CMD_TICK, 0, 0, 0, 1'b0));
    send_cmd(mk_cmd(dsrsc_pkg::CMD_STRAIGHT, 127, 0, 0, 1'b0));
    send_cmd(mk_cmd(dsrsc_pkg::CMD_STRAIGHT, -128, 0, 0, 1'b1));
    send_cmd(mk_cmd(dsrsc_pkg::CMD_TICK, 0, 0, 0, 1'b1));
    send_cmd(mk_cmd(dsrsc_pkg::CMD_LEFT, 50, 255, 0, 1'b0));
    send_cmd(mk_cmd(dsrsc_pkg::CMD_RIGHT, -50, 100, 0, 1'b0));
    send_cmd(mk_cmd(dsrsc_pkg::CMD_LEFT, -50, 0, 0, 1'b0));
    send_cmd(mk_cmd(dsrsc_pkg::CMD_PULSE, 100, 0, 65535, 1'b0));
    send_cmd(mk_cmd(dsrsc_pkg::CMD_PULSE, -100, 0, 0, 1'b0));
    send_cmd(mk_cmd(dsrsc_pkg::CMD_STEER, 0, 0, 1002, 1'b0));
    send_cmd(mk_cmd(dsrsc_pkg::CMD_STEER, 0, 0, 4095, 1'b1));
    send_cmd(mk_cmd(dsrsc_pkg::CMD_STOP, 0, 0, 0, 1'b1));
    send_cmd(mk_cmd(dsrsc_pkg::CMD_STOP, 0, 0, 0, 1'b0));
    send_cmd(mk_cmd(CMD_UNUSED, 127, 255, 65535, 1'b1));
    send_cmd(mk_cmd(dsrsc_pkg::CMD_STRAIGHT, 0, 0, 0, 1'b0));
    drain();

    // Slow ramp, crossed servo limits with the center outside them, and ramped mode.
    program_regs(3, 200, 1, 2200, 1500, 1800, 5, 0);
    send_cmd(mk_cmd(dsrsc_pkg::CMD_STRAIGHT, 100, 0, 0, 1'b0));
    repeat (3) send_cmd(mk_cmd(dsrsc_pkg::CMD_TICK, 0, 0, 0, 1'b0));
    send_cmd(mk_cmd(dsrsc_pkg::CMD_RIGHT, -100, 80, 0, 1'b0));
    send_cmd(mk_cmd(dsrsc_pkg::CMD_TICK, 0, 0, 0, 1'b0));
    send_cmd(mk_cmd(dsrsc_pkg::CMD_LEFT, 0, 255, 0, 1'b0));
    send_cmd(mk_cmd(dsrsc_pkg::CMD_TICK, 0, 0, 0, 1'b0));
    send_cmd(mk_cmd(dsrsc_pkg::CMD_TICK, 0, 0, 0, 1'b1));
    send_cmd(mk_cmd(dsrsc_pkg::CMD_PULSE, 127, 0, 2000, 1'b1));
    drain();

    program_regs(5, 10, 1, 1000, 1500, 2000, 5, 1);
    run_random(PHASE_ITEMS);
    program_regs(1, 1, 0, 0, 0, 4095, 0, 0);
    run_random(PHASE_ITEMS);
    program_regs(200, 200, 200, 4095, 4095, 0, 4095, 1);
    run_random(PHASE_ITEMS);
    program_regs(200, 1, 0, 0, 2048, 4095, 0, 0);
    run_random(PHASE_ITEMS);
    repeat (RANDOM_PHASES - 4) begin
      random_setting();
      run_random(PHASE_ITEMS);
    end

    repeat (4) @(negedge clk);
    if (errors == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

>>> files.f
design/dsrsc_pkg.sv
design/drive_speed_ramp_steering_cmd.sv
test/drive_speed_ramp_steering_cmd_checker.sv
test/tb_drive_speed_ramp_steering_cmd.sv
